FILE: rtl/v3au_pkg.sv
`default_nettype none

package v3au_pkg;

    localparam int FIELD_BITS  = 32;
    localparam int FUNC_BITS   = 4;
    localparam int STATUS_BITS = 2;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_ADD   = 4'd0,
        FN_SUB   = 4'd1,
        FN_MUL   = 4'd2,
        FN_SCALE = 4'd3,
        FN_DIV   = 4'd4,
        FN_DOT   = 4'd5,
        FN_CROSS = 4'd6,
        FN_LENSQ = 4'd7,
        FN_LEN   = 4'd8,
        FN_NORM  = 4'd9,
        FN_NEG   = 4'd10
    } t_func;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/v3au_lane.sv
`default_nettype none

module v3au_lane #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [v3au_pkg::FUNC_BITS-1:0]     i_func,
    input  logic signed [W-1:0]                i_a0,
    input  logic signed [W-1:0]                i_b0,
    input  logic signed [W-1:0]                i_a1,
    input  logic signed [W-1:0]                i_b1,
    input  logic signed [W-1:0]                i_u,
    input  logic signed [W-1:0]                i_v,
    output logic signed [2*W:0]                o_d,
    output logic signed [W-1:0]                o_r,
    output logic                               o_sat
);
    import v3au_pkg::*;

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    logic signed [2*W-1:0]   r_p0, r_p1;
    logic signed [W-1:0]     r_u, r_v;
    logic [FUNC_BITS-1:0]    r_fa, r_fb;
    logic signed [2*W:0]     r_d;
    logic signed [W:0]       r_e;
    logic signed [W:0]       n_e;
    logic signed [2*W-F:0]   n_q;
    logic                    n_qovf;
    logic signed [W-1:0]     n_r;
    logic                    n_sat;
    logic signed [W-1:0]     r_r;
    logic                    r_sat;

    always_comb begin
        case (r_fa)
            FN_ADD:  n_e = (W+1)'(r_u) + (W+1)'(r_v);
            FN_SUB:  n_e = (W+1)'(r_u) - (W+1)'(r_v);
            FN_NEG:  n_e = -((W+1)'(r_u));
            default: n_e = '0;
        endcase
    end

    always_comb begin
        n_q    = (2*W+1-F)'(r_d >>> F);
        n_qovf = !((&n_q[2*W-F:W-1]) || (~|n_q[2*W-F:W-1]));
        n_r    = '0;
        n_sat  = 1'b0;
        case (r_fb)
            FN_ADD, FN_SUB, FN_NEG: begin
                if (r_e[W] != r_e[W-1]) begin
                    n_r   = r_e[W] ? WMIN : WMAX;
                    n_sat = 1'b1;
                end else begin
                    n_r = r_e[W-1:0];
                end
            end
            FN_MUL, FN_SCALE, FN_CROSS: begin
                if (n_qovf) begin
                    n_r   = n_q[2*W-F] ? WMIN : WMAX;
                    n_sat = 1'b1;
                end else begin
                    n_r = n_q[W-1:0];
                end
            end
            default: begin
                n_r   = '0;
                n_sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= i_a0 * i_b0;
            r_p1  <= i_a1 * i_b1;
            r_u   <= i_u;
            r_v   <= i_v;
            r_fa  <= i_func;
            r_d   <= (2*W+1)'(r_p0) - (2*W+1)'(r_p1);
            r_e   <= n_e;
            r_fb  <= r_fa;
            r_r   <= n_r;
            r_sat <= n_sat;
        end
    end

    assign o_d   = r_d;
    assign o_r   = r_r;
    assign o_sat = r_sat;

endmodule

`default_nettype wire

FILE: rtl/v3au_sqrt.sv
`default_nettype none

module v3au_sqrt #(
    parameter int W = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [2*W-1:0]   i_val,
    output logic [W-1:0]     o_root
);

    localparam int R = W + 2;

    logic [R-1:0]   r_rem  [0:W-1];
    logic [W-1:0]   r_root [0:W-1];
    logic [2*W-1:0] r_x    [0:W-1];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [R-1:0]   s_rem;
        logic [W-1:0]   s_root;
        logic [2*W-1:0] s_x;
        logic [R+1:0]   n_try;
        logic [R+1:0]   n_sub;
        logic           n_ge;

        if (k == 0) begin : g_first
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_x    = i_val;
        end else begin : g_next
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_x    = r_x[k-1];
        end

        assign n_try = {s_rem, s_x[2*W-1:2*W-2]};
        assign n_sub = (R+2)'({s_root, 2'b01});
        assign n_ge  = (n_try >= n_sub);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? R'(n_try - n_sub) : R'(n_try);
                r_root[k] <= {s_root[W-2:0], n_ge};
                r_x[k]    <= {s_x[2*W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[W-1];

endmodule

`default_nettype wire

FILE: rtl/v3au_div.sv
`default_nettype none

module v3au_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [W-1:0]     i_num,
    input  logic [W-1:0]     i_den,
    output logic [W+F-1:0]   o_quo
);

    localparam int NS = W + F;

    logic [W-1:0]  r_rem [0:NS-1];
    logic [NS-1:0] r_x   [0:NS-1];
    logic [W-1:0]  r_den [0:NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [W-1:0]  s_rem;
        logic [NS-1:0] s_x;
        logic [W-1:0]  s_den;
        logic [W:0]    n_try;
        logic          n_ge;

        if (k == 0) begin : g_first
            assign s_rem = '0;
            assign s_x   = {i_num, {F{1'b0}}};
            assign s_den = i_den;
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_x   = r_x[k-1];
            assign s_den = r_den[k-1];
        end

        assign n_try = {s_rem, s_x[NS-1]};
        assign n_ge  = (n_try >= {1'b0, s_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? W'(n_try - {1'b0, s_den}) : n_try[W-1:0];
                r_x[k]   <= {s_x[NS-2:0], n_ge};
                r_den[k] <= s_den;
            end
        end
    end

    assign o_quo = r_x[NS-1];

endmodule

`default_nettype wire

FILE: rtl/vec3_arithmetic_unit.sv
// Channel   Valid     Stall     Payload
// request   i_valid   o_stall   i_func, i_u_x/y/z, i_v_x/y/z, i_scale
// result    o_valid   i_stall   o_r_x/y/z, o_scalar_out, o_status
//
// One request per cycle while o_stall is low; each passes through the WORD_BITS-stage
// square root and then the WORD_BITS+FRAC_BITS-stage dividers.
// i_rst_n is synchronous, active low, and clears the valid bits only.
// A held result under i_stall freezes the whole pipeline; o_stall follows it.
`default_nettype none

module vec3_arithmetic_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [v3au_pkg::FUNC_BITS-1:0]         i_func,
    input  logic signed [v3au_pkg::FIELD_BITS-1:0] i_u_x,
    input  logic signed [v3au_pkg::FIELD_BITS-1:0] i_u_y,
    input  logic signed [v3au_pkg::FIELD_BITS-1:0] i_u_z,
    input  logic signed [v3au_pkg::FIELD_BITS-1:0] i_v_x,
    input  logic signed [v3au_pkg::FIELD_BITS-1:0] i_v_y,
    input  logic signed [v3au_pkg::FIELD_BITS-1:0] i_v_z,
    input  logic signed [v3au_pkg::FIELD_BITS-1:0] i_scale,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [v3au_pkg::FIELD_BITS-1:0] o_r_x,
    output logic signed [v3au_pkg::FIELD_BITS-1:0] o_r_y,
    output logic signed [v3au_pkg::FIELD_BITS-1:0] o_r_z,
    output logic signed [v3au_pkg::FIELD_BITS-1:0] o_scalar_out,
    output logic [v3au_pkg::STATUS_BITS-1:0]       o_status
);
    import v3au_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int NS = W + F;
    localparam int SW = 2 * W + 3;

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [NS-1:0] QPOS_LIM = {{(F+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [NS-1:0] QNEG_LIM = {{F{1'b0}}, 1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [W-1:0]         t;
        logic [2:0][W-1:0]    u;
        logic [2:0][W-1:0]    r;
        logic [2:0]           ovf;
        logic [W-1:0]         sc;
        logic                 sc_ovf;
        logic                 dz;
        logic [2:0]           qneg;
    } t_side;

    logic en;

    logic signed [W-1:0] w_u [3];
    logic signed [W-1:0] w_v [3];
    logic signed [W-1:0] w_t;

    logic signed [2*W:0] w_d   [3];
    logic signed [W-1:0] w_r   [3];
    logic                w_sat [3];

    logic                 r_va, r_vb, r_vc;
    logic [FUNC_BITS-1:0] r_fa, r_fb, r_fc;
    logic signed [W-1:0]  r_ta, r_tb, r_tc;
    logic signed [W-1:0]  r_ua [3];
    logic signed [W-1:0]  r_ub [3];
    logic signed [W-1:0]  r_uc [3];
    logic signed [SW-1:0] r_sum;

    logic [SW-F-1:0] n_q;
    logic            n_qovf;
    t_side           n_side;

    t_side r_sq_side [0:W-1];
    logic  r_sq_vld  [0:W-1];
    logic [W-1:0] w_root;

    t_side        n_dside;
    logic [W-1:0] n_den;
    logic [W-1:0] n_num [3];
    logic         n_dneg;
    t_side        r_dside;
    logic         r_dvld;
    logic [W-1:0] r_den;
    logic [W-1:0] r_num [3];
    logic [NS-1:0] w_quo [3];

    t_side r_dv_side [0:NS-1];
    logic  r_dv_vld  [0:NS-1];

    t_side               w_e;
    logic signed [W-1:0] n_out_r [3];
    logic signed [W-1:0] n_out_sc;
    logic [STATUS_BITS-1:0] n_out_st;
    logic [2:0]          n_qsat;
    logic signed [W-1:0] n_qres [3];

    logic                   r_out_vld;
    logic signed [W-1:0]    r_out_r [3];
    logic signed [W-1:0]    r_out_sc;
    logic [STATUS_BITS-1:0] r_out_st;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    assign w_u[0] = W'(i_u_x);
    assign w_u[1] = W'(i_u_y);
    assign w_u[2] = W'(i_u_z);
    assign w_v[0] = W'(i_v_x);
    assign w_v[1] = W'(i_v_y);
    assign w_v[2] = W'(i_v_z);
    assign w_t    = W'(i_scale);

    for (genvar i = 0; i < 3; i++) begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        logic signed [W-1:0] a0, b0, a1, b1;

        always_comb begin
            a0 = '0;
            b0 = '0;
            a1 = '0;
            b1 = '0;
            case (i_func)
                FN_MUL, FN_DOT: begin
                    a0 = w_u[i];
                    b0 = w_v[i];
                end
                FN_SCALE: begin
                    a0 = w_t;
                    b0 = w_u[i];
                end
                FN_CROSS: begin
                    a0 = w_u[J];
                    b0 = w_v[K];
                    a1 = w_u[K];
                    b1 = w_v[J];
                end
                FN_LENSQ, FN_LEN, FN_NORM: begin
                    a0 = w_u[i];
                    b0 = w_u[i];
                end
                default: begin
                    a0 = '0;
                end
            endcase
        end

        v3au_lane #(.W(W), .F(F)) u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_func (i_func),
            .i_a0   (a0),
            .i_b0   (b0),
            .i_a1   (a1),
            .i_b1   (b1),
            .i_u    (w_u[i]),
            .i_v    (w_v[i]),
            .o_d    (w_d[i]),
            .o_r    (w_r[i]),
            .o_sat  (w_sat[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fa <= i_func;
            r_ta <= w_t;
            r_fb <= r_fa;
            r_tb <= r_ta;
            r_fc <= r_fb;
            r_tc <= r_tb;
            for (int i = 0; i < 3; i++) begin
                r_ua[i] <= w_u[i];
                r_ub[i] <= r_ua[i];
                r_uc[i] <= r_ub[i];
            end
            r_sum <= SW'(w_d[0]) + SW'(w_d[1]) + SW'(w_d[2]);
        end
    end

    always_comb begin
        n_q    = (SW-F)'(r_sum >>> F);
        n_qovf = !((&n_q[SW-F-1:W-1]) || (~|n_q[SW-F-1:W-1]));
        n_side.func   = r_fc;
        n_side.t      = r_tc;
        n_side.dz     = 1'b0;
        n_side.qneg   = '0;
        n_side.sc     = '0;
        n_side.sc_ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_side.u[i]   = r_uc[i];
            n_side.r[i]   = w_r[i];
            n_side.ovf[i] = w_sat[i];
        end
        if (r_fc == FN_DOT || r_fc == FN_LENSQ) begin
            n_side.sc_ovf = n_qovf;
            if (n_qovf) begin
                n_side.sc = n_q[SW-F-1] ? WMIN : WMAX;
            end else begin
                n_side.sc = n_q[W-1:0];
            end
        end
    end

    v3au_sqrt #(.W(W)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_sum[2*W-1:0]),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_side[0] <= n_side;
            for (int k = 1; k < W; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
        end
    end

    always_comb begin
        n_dside = r_sq_side[W-1];
        n_dneg  = 1'b0;
        n_den   = w_root;
        if (n_dside.func == FN_DIV) begin
            n_dneg = n_dside.t[W-1];
            n_den  = n_dside.t[W-1] ? (~n_dside.t + 1'b1) : n_dside.t;
        end
        n_dside.dz = (n_dside.func == FN_DIV && n_dside.t == '0) ||
                     (n_dside.func == FN_NORM && w_root == '0);
        if (n_dside.func == FN_LEN) begin
            n_dside.sc_ovf = w_root[W-1];
            n_dside.sc     = w_root[W-1] ? WMAX : w_root;
        end
        for (int i = 0; i < 3; i++) begin
            n_num[i]          = n_dside.u[i][W-1] ? (~n_dside.u[i] + 1'b1) : n_dside.u[i];
            n_dside.qneg[i]   = n_dside.u[i][W-1] ^ n_dneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dside <= n_dside;
            r_den   <= n_den;
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= n_num[i];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        v3au_div #(.W(W), .F(F)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_num[i]),
            .i_den (r_den),
            .o_quo (w_quo[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_side[0] <= r_dside;
            for (int k = 1; k < NS; k++) begin
                r_dv_side[k] <= r_dv_side[k-1];
            end
        end
    end

    assign w_e = r_dv_side[NS-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_qsat[i] = 1'b0;
            if (w_e.qneg[i]) begin
                if (w_quo[i] > QNEG_LIM) begin
                    n_qres[i] = WMIN;
                    n_qsat[i] = 1'b1;
                end else begin
                    n_qres[i] = W'(~w_quo[i] + 1'b1);
                end
            end else begin
                if (w_quo[i] > QPOS_LIM) begin
                    n_qres[i] = WMAX;
                    n_qsat[i] = 1'b1;
                end else begin
                    n_qres[i] = w_quo[i][W-1:0];
                end
            end
        end
        n_out_sc = w_e.sc;
        if (w_e.func == FN_DIV || w_e.func == FN_NORM) begin
            for (int i = 0; i < 3; i++) begin
                n_out_r[i] = n_qres[i];
            end
            n_out_st = (|n_qsat || w_e.sc_ovf) ? ST_SAT : ST_OK;
        end else begin
            for (int i = 0; i < 3; i++) begin
                n_out_r[i] = w_e.r[i];
            end
            n_out_st = (|w_e.ovf || w_e.sc_ovf) ? ST_SAT : ST_OK;
        end
        if (w_e.dz) begin
            for (int i = 0; i < 3; i++) begin
                n_out_r[i] = '0;
            end
            n_out_sc = '0;
            n_out_st = ST_DIVZ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_sc <= n_out_sc;
            r_out_st <= n_out_st;
            for (int i = 0; i < 3; i++) begin
                r_out_r[i] <= n_out_r[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va      <= 1'b0;
            r_vb      <= 1'b0;
            r_vc      <= 1'b0;
            r_dvld    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < W; k++) begin
                r_sq_vld[k] <= 1'b0;
            end
            for (int k = 0; k < NS; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_va        <= i_valid;
            r_vb        <= r_va;
            r_vc        <= r_vb;
            r_sq_vld[0] <= r_vc;
            for (int k = 1; k < W; k++) begin
                r_sq_vld[k] <= r_sq_vld[k-1];
            end
            r_dvld      <= r_sq_vld[W-1];
            r_dv_vld[0] <= r_dvld;
            for (int k = 1; k < NS; k++) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
            r_out_vld   <= r_dv_vld[NS-1];
        end
    end

    assign o_valid      = r_out_vld;
    assign o_r_x        = FIELD_BITS'(r_out_r[0]);
    assign o_r_y        = FIELD_BITS'(r_out_r[1]);
    assign o_r_z        = FIELD_BITS'(r_out_r[2]);
    assign o_scalar_out = FIELD_BITS'(r_out_sc);
    assign o_status     = r_out_st;

`ifndef SYNTHESIS
    localparam logic signed [FIELD_BITS-1:0] XMAX = FIELD_BITS'(WMAX);
    localparam logic signed [FIELD_BITS-1:0] XMIN = FIELD_BITS'(WMIN);

    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DIVZ) |->
        (o_r_x == '0 && o_r_y == '0 && o_r_z == '0 && o_scalar_out == '0))
        else $error("divide-by-zero result not cleared");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SAT) |->
        (o_r_x == XMAX || o_r_x == XMIN || o_r_y == XMAX || o_r_y == XMIN ||
         o_r_z == XMAX || o_r_z == XMIN ||
         o_scalar_out == XMAX || o_scalar_out == XMIN))
        else $error("saturated status without a clamped field");
`endif

endmodule

`default_nettype wire
